/* sv/tcs_pkg.sv */
// Shared codes for the totient chain sieve: action, status and register codes and reset values.
`timescale 1ns / 1ps
package tcs_pkg;

  localparam logic [1:0] ACT_BUILD = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_SUM   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic       REG_LIMIT  = 1'b0;
  localparam logic       REG_TARGET = 1'b1;

  localparam logic [16:0] LIMIT_RST  = 17'd65536;
  localparam logic [4:0]  TARGET_RST = 5'd25;
  localparam logic [4:0]  CHAIN_MAX  = 5'd31;

endpackage

/* sv/totient_chain_sieve_top.sv */
// Totient chain sieve: table build over one bit-serial divider, query and prime sum.
//
//  channel  | direction | handshake                  | payload
//  s_axis   | in        | s_axis_tvalid/tready       | tdata: action[1:0], index[17:2]
//  m_axis   | out       | m_axis_tvalid/tready       | tdata: totient, chain, prime, total, status
//  cfg      | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A query reads both tables at its index; a sum walks the table entries. A build
// seeds each entry, tests each prime candidate, updates each prime multiple with
// the bit-serial divider, and then runs the chain pass over each entry.
// The single read port of each table memory and the divider pace these steps.
// Reset clears the control state and the built flag; the tables are not cleared.
// Input is taken only when idle; a result held only at the output does not block it.
`timescale 1ns / 1ps
module totient_chain_sieve_top #(
  parameter int MAX_N = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // action[1:0], index[17:2], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // totient[15:0], chain_length[20:16],
                                      // is_prime[21], total[53:22], status[55:54]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_N);
  localparam int LW = (AW + 1 > 17) ? AW + 1 : 17;
  localparam int CW = $clog2(AW);
  localparam logic [LW-1:0] MAXN_L = LW'(MAX_N);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_PRD   = 5'd2;
  localparam logic [4:0] S_PCHK  = 5'd3;
  localparam logic [4:0] S_NRD   = 5'd4;
  localparam logic [4:0] S_NDIV  = 5'd5;
  localparam logic [4:0] S_DIV   = 5'd6;
  localparam logic [4:0] S_NWR   = 5'd7;
  localparam logic [4:0] S_C1    = 5'd8;
  localparam logic [4:0] S_CRD   = 5'd9;
  localparam logic [4:0] S_CPREV = 5'd10;
  localparam logic [4:0] S_CWR   = 5'd11;
  localparam logic [4:0] S_SRD   = 5'd12;
  localparam logic [4:0] S_SACC  = 5'd13;
  localparam logic [4:0] S_QRD   = 5'd14;
  localparam logic [4:0] S_QOUT  = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  logic [4:0]    state_q, state_d;
  logic [16:0]   limit_q;
  logic [4:0]    target_q;
  logic          built_q, built_d;
  logic [LW-1:0] blim_q, blim_d, lim_q, lim_d;
  logic [LW-1:0] i_q, i_d, p_q, p_d, n_q, n_d;
  logic [AW-1:0] dvd_q, dvd_d, ent_q, ent_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   r_tot_q, r_tot_d;
  logic [4:0]    r_chain_q, r_chain_d;
  logic          r_prime_q, r_prime_d;
  logic [31:0]   r_total_q, r_total_d;
  logic [1:0]    r_status_q, r_status_d;
  logic          m_valid_q, m_valid_d;
  logic [55:0]   m_data_q, m_data_d;

  logic [LW-1:0] cap_lim, act_lim;
  logic [AW-1:0] tot_raddr, tot_waddr, tot_wd, tot_rd_q;
  logic          tot_we;
  logic [AW-1:0] ch_raddr, ch_waddr;
  logic [4:0]    ch_wd, ch_rd_q;
  logic          ch_we;
  logic [AW:0]   rem_sh;
  logic          div_ge;
  logic [1:0]    in_action;
  logic [15:0]   in_index;
  logic          in_xfer;

  logic [AW-1:0] tot_mem [MAX_N];
  logic [4:0]    ch_mem  [MAX_N];

  assign in_action     = s_axis_tdata[1:0];
  assign in_index      = s_axis_tdata[17:2];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Effective limits: current limit capped at the table depth, then at the built range.
  assign cap_lim = (LW'(limit_q) > MAXN_L) ? MAXN_L : LW'(limit_q);
  assign act_lim = (cap_lim < blim_q) ? cap_lim : blim_q;

  // One restoring divider step: shift in the next dividend bit and try to subtract.
  assign rem_sh = {rem_q, dvd_q[AW-1]};
  assign div_ge = rem_sh >= {1'b0, AW'(p_q)};

  // Table memories, one read and one write port each, registered read data.
  always_ff @(posedge clk_i) begin
    tot_rd_q <= tot_mem[tot_raddr];
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_rd_q <= ch_mem[ch_raddr];
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wd;
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    built_d    = built_q;
    blim_d     = blim_q;
    lim_d      = lim_q;
    i_d        = i_q;
    p_d        = p_q;
    n_d        = n_q;
    dvd_d      = dvd_q;
    ent_d      = ent_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    r_tot_d    = r_tot_q;
    r_chain_d  = r_chain_q;
    r_prime_d  = r_prime_q;
    r_total_d  = r_total_q;
    r_status_d = r_status_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    tot_raddr  = AW'(i_q);
    ch_raddr   = AW'(i_q);
    tot_we     = 1'b0;
    tot_waddr  = AW'(i_q);
    tot_wd     = AW'(i_q);
    ch_we      = 1'b0;
    ch_waddr   = AW'(i_q);
    ch_wd      = 5'd1;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          r_tot_d    = '0;
          r_chain_d  = '0;
          r_prime_d  = 1'b0;
          r_total_d  = '0;
          r_status_d = tcs_pkg::ST_OK;
          state_d    = S_DONE;
          case (in_action)
            tcs_pkg::ACT_BUILD: begin
              lim_d   = cap_lim;
              i_d     = LW'(1);
              state_d = S_INIT;
            end
            tcs_pkg::ACT_QUERY: begin
              i_d = LW'(in_index);
              if (!built_q) begin
                r_status_d = tcs_pkg::ST_NOT_BUILT;
              end else if (in_index == 16'd0 || LW'(in_index) >= act_lim) begin
                r_status_d = tcs_pkg::ST_RANGE;
              end else begin
                state_d = S_QRD;
              end
            end
            tcs_pkg::ACT_SUM: begin
              i_d = LW'(2);
              if (!built_q) begin
                r_status_d = tcs_pkg::ST_NOT_BUILT;
              end else begin
                state_d = S_SRD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // Seed every entry from 1 up to the limit with its own index.
      S_INIT: begin
        if (i_q >= lim_q) begin
          p_d     = LW'(2);
          state_d = S_PRD;
        end else begin
          tot_we = 1'b1;
          i_d    = i_q + LW'(1);
        end
      end
      S_PRD: begin
        tot_raddr = AW'(p_q);
        if (p_q >= lim_q) begin
          state_d = S_C1;
        end else begin
          state_d = S_PCHK;
        end
      end
      // An untouched entry marks a prime.
      S_PCHK: begin
        if (LW'(tot_rd_q) == p_q) begin
          n_d     = p_q;
          state_d = S_NRD;
        end else begin
          p_d     = p_q + LW'(1);
          state_d = S_PRD;
        end
      end
      S_NRD: begin
        tot_raddr = AW'(n_q);
        if (n_q >= lim_q) begin
          p_d     = p_q + LW'(1);
          state_d = S_PRD;
        end else begin
          state_d = S_NDIV;
        end
      end
      S_NDIV: begin
        dvd_d   = tot_rd_q;
        ent_d   = tot_rd_q;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = div_ge ? AW'(rem_sh - {1'b0, AW'(p_q)}) : rem_sh[AW-1:0];
        dvd_d = {dvd_q[AW-2:0], div_ge};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(AW - 1)) begin
          state_d = S_NWR;
        end
      end
      // The entry is a multiple of p, so entry/p*(p-1) is entry minus quotient.
      S_NWR: begin
        tot_we    = 1'b1;
        tot_waddr = AW'(n_q);
        tot_wd    = ent_q - dvd_q;
        n_d       = n_q + p_q;
        state_d   = S_NRD;
      end
      S_C1: begin
        ch_waddr = AW'(1);
        ch_we    = lim_q > LW'(1);
        i_d      = LW'(2);
        state_d  = S_CRD;
      end
      S_CRD: begin
        if (i_q >= lim_q) begin
          built_d = 1'b1;
          blim_d  = lim_q;
          state_d = S_DONE;
        end else begin
          state_d = S_CPREV;
        end
      end
      S_CPREV: begin
        ch_raddr = tot_rd_q;
        if (LW'(tot_rd_q) < lim_q) begin
          state_d = S_CWR;
        end else begin
          ch_we   = 1'b1;
          i_d     = i_q + LW'(1);
          state_d = S_CRD;
        end
      end
      S_CWR: begin
        ch_we   = 1'b1;
        ch_wd   = (ch_rd_q == tcs_pkg::CHAIN_MAX) ? tcs_pkg::CHAIN_MAX : ch_rd_q + 5'd1;
        i_d     = i_q + LW'(1);
        state_d = S_CRD;
      end
      // Sum walk: read both tables at i, then test and accumulate.
      S_SRD: begin
        if (i_q >= act_lim) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SACC;
        end
      end
      S_SACC: begin
        if (LW'(tot_rd_q) == i_q - LW'(1) && ch_rd_q == target_q) begin
          r_total_d = r_total_q + 32'(i_q);
        end
        i_d     = i_q + LW'(1);
        state_d = S_SRD;
      end
      S_QRD: begin
        state_d = S_QOUT;
      end
      S_QOUT: begin
        r_tot_d   = 16'(tot_rd_q);
        r_chain_d = ch_rd_q;
        r_prime_d = LW'(tot_rd_q) == i_q - LW'(1);
        state_d   = S_DONE;
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {r_status_q, r_total_q, r_prime_q, r_chain_q, r_tot_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      limit_q    <= tcs_pkg::LIMIT_RST;
      target_q   <= tcs_pkg::TARGET_RST;
      built_q    <= 1'b0;
      blim_q     <= '0;
      lim_q      <= '0;
      i_q        <= '0;
      p_q        <= '0;
      n_q        <= '0;
      dvd_q      <= '0;
      ent_q      <= '0;
      rem_q      <= '0;
      cnt_q      <= '0;
      r_tot_q    <= '0;
      r_chain_q  <= '0;
      r_prime_q  <= 1'b0;
      r_total_q  <= '0;
      r_status_q <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      built_q    <= built_d;
      blim_q     <= blim_d;
      lim_q      <= lim_d;
      i_q        <= i_d;
      p_q        <= p_d;
      n_q        <= n_d;
      dvd_q      <= dvd_d;
      ent_q      <= ent_d;
      rem_q      <= rem_d;
      cnt_q      <= cnt_d;
      r_tot_q    <= r_tot_d;
      r_chain_q  <= r_chain_d;
      r_prime_q  <= r_prime_d;
      r_total_q  <= r_total_d;
      r_status_q <= r_status_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
      // Configuration register writes.
      if (cfg_valid_i) begin
        if (cfg_index_i == tcs_pkg::REG_LIMIT) begin
          limit_q <= cfg_data_i;
        end else begin
          target_q <= cfg_data_i[4:0];
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_built_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |=> built_q) else $error("built flag fell");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_DONE) else $error("result not from done");
  a_chain_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_we |-> ch_wd != 5'd0) else $error("zero chain length written");
  a_tot_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_we && state_q == S_NWR) |-> tot_wd < ent_q) else $error("totient did not shrink");
`endif

endmodule

/* tb/sv/totient_chain_sieve_top_tb.sv */
// Self-checking testbench for the totient chain sieve: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module totient_chain_sieve_top_tb;

  localparam int          TABLE_DEPTH = 65536;
  localparam logic [1:0]  ACT_NONE    = 2'd3;
  localparam int          N_PHASES    = 10;
  localparam int          PHASE_ITEMS = 100;
  localparam int          SETTLE_CYC  = 20;

  typedef struct packed {
    logic [15:0] totient;
    logic [4:0]  chain;
    logic        prime;
    logic [31:0] total;
    logic [1:0]  status;
  } sieve_res_t;

  typedef enum logic [1:0] {RK_ITEM, RK_LIMIT, RK_TARGET} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  act;
    logic [16:0] val;
    logic        typed;
    sieve_res_t  res;
  } dir_row_t;

  localparam sieve_res_t R_ZERO = '{16'd0, 5'd0, 1'b0, 32'd0, tcs_pkg::ST_OK};
  localparam sieve_res_t R_NOTB = '{16'd0, 5'd0, 1'b0, 32'd0, tcs_pkg::ST_NOT_BUILT};
  localparam sieve_res_t R_RNG  = '{16'd0, 5'd0, 1'b0, 32'd0, tcs_pkg::ST_RANGE};
  localparam sieve_res_t R_ONE  = '{16'd1, 5'd1, 1'b0, 32'd0, tcs_pkg::ST_OK};

  localparam int N_DIR = 25;
  dir_row_t dir_rows [N_DIR] = '{
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'd5,      1'b1, R_NOTB},
    '{RK_ITEM,   tcs_pkg::ACT_SUM,   17'd0,      1'b1, R_NOTB},
    '{RK_ITEM,   ACT_NONE,           17'hFFFF,   1'b1, R_ZERO},
    '{RK_LIMIT,  tcs_pkg::ACT_BUILD, 17'd2,      1'b0, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_BUILD, 17'd0,      1'b1, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'd1,      1'b1, R_ONE},
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'd2,      1'b1, R_RNG},
    '{RK_ITEM,   tcs_pkg::ACT_SUM,   17'd0,      1'b1, R_ZERO},
    '{RK_LIMIT,  tcs_pkg::ACT_BUILD, 17'd0,      1'b0, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_BUILD, 17'd0,      1'b1, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'd1,      1'b1, R_RNG},
    '{RK_LIMIT,  tcs_pkg::ACT_BUILD, 17'd100,    1'b0, R_ZERO},
    '{RK_TARGET, tcs_pkg::ACT_BUILD, 17'd1,      1'b0, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_BUILD, 17'd0,      1'b1, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'd0,      1'b1, R_RNG},
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'd97,     1'b0, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'd100,    1'b1, R_RNG},
    '{RK_ITEM,   tcs_pkg::ACT_SUM,   17'd0,      1'b0, R_ZERO},
    '{RK_TARGET, tcs_pkg::ACT_BUILD, 17'd31,     1'b0, R_ZERO},
    '{RK_LIMIT,  tcs_pkg::ACT_BUILD, 17'd65536,  1'b0, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_BUILD, 17'd0,      1'b1, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_QUERY, 17'hFFFF,   1'b0, R_ZERO},
    '{RK_TARGET, tcs_pkg::ACT_BUILD, 17'd25,     1'b0, R_ZERO},
    '{RK_ITEM,   tcs_pkg::ACT_SUM,   17'd0,      1'b0, R_ZERO},
    '{RK_LIMIT,  tcs_pkg::ACT_BUILD, 17'h1FFFF,  1'b0, R_ZERO}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = tcs_pkg::REG_LIMIT;
  logic [16:0] cfg_data_i = '0;

  // Predictor state.
  int unsigned phi_tab [TABLE_DEPTH];
  logic [4:0]  chain_tab [TABLE_DEPTH];
  bit          tables_ok = 1'b0;
  int unsigned built_lim = 0;
  int unsigned lim_reg = 32'(tcs_pkg::LIMIT_RST);
  logic [4:0]  target_reg = tcs_pkg::TARGET_RST;

  sieve_res_t  expected_q [$];
  int          err_cnt = 0;
  bit          burst_mode = 1'b0;

  totient_chain_sieve_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Effective limit for queries and sums.
  function automatic int unsigned live_limit();
    int unsigned cur;
    cur = (lim_reg > TABLE_DEPTH) ? TABLE_DEPTH : lim_reg;
    return (cur < built_lim) ? cur : built_lim;
  endfunction

  // Sieve the totient table, then derive chain lengths.
  task automatic sieve_tables();
    int unsigned lim, prev;
    logic [4:0]  c;
    lim = (lim_reg > TABLE_DEPTH) ? TABLE_DEPTH : lim_reg;
    for (int unsigned i = 1; i < lim; i++) phi_tab[i] = i;
    for (int unsigned p = 2; p < lim; p++) begin
      if (phi_tab[p] == p) begin
        for (int unsigned n = p; n < lim; n += p) phi_tab[n] = phi_tab[n] / p * (p - 1);
      end
    end
    if (lim > 1) chain_tab[1] = 5'd1;
    for (int unsigned i = 2; i < lim; i++) begin
      prev = phi_tab[i];
      c = (prev < lim) ? chain_tab[prev] : 5'd0;
      chain_tab[i] = (c >= tcs_pkg::CHAIN_MAX) ? tcs_pkg::CHAIN_MAX : c + 5'd1;
    end
    built_lim = lim;
    tables_ok = 1'b1;
  endtask

  task automatic predict_sieve(input logic [1:0] act, input logic [15:0] idx,
                               output sieve_res_t r);
    int unsigned lim;
    r = R_ZERO;
    case (act)
      tcs_pkg::ACT_BUILD: begin
        sieve_tables();
      end
      tcs_pkg::ACT_QUERY: begin
        if (!tables_ok) begin
          r.status = tcs_pkg::ST_NOT_BUILT;
        end else if (idx == 0 || idx >= live_limit()) begin
          r.status = tcs_pkg::ST_RANGE;
        end else begin
          r.totient = phi_tab[idx][15:0];
          r.chain   = chain_tab[idx];
          r.prime   = (phi_tab[idx] == idx - 1);
        end
      end
      tcs_pkg::ACT_SUM: begin
        if (!tables_ok) begin
          r.status = tcs_pkg::ST_NOT_BUILT;
        end else begin
          lim = live_limit();
          for (int unsigned i = 2; i < lim; i++) begin
            if (phi_tab[i] == i - 1 && chain_tab[i] == target_reg) r.total += i;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // One input transfer; valid stays high when no gap follows, so back-to-back items need no toggle.
  task automatic send_item(input logic [1:0] act, input logic [15:0] idx,
                           input bit typed, input sieve_res_t typed_res);
    sieve_res_t r;
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, idx, act};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sieve(act, idx, r);
    expected_q.push_back(typed ? typed_res : r);
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // Register write, issued only once all results are back.
  task automatic write_reg(input logic which, input logic [16:0] value);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (which == tcs_pkg::REG_LIMIT) lim_reg = 32'(value);
    else target_reg = value[4:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Output backpressure: short and occasional long stalls, with stall-free stretches.
  initial begin
    int stall;
    int mode_cnt;
    bit calm;
    stall = 0;
    mode_cnt = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_cnt == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_cnt = $urandom_range(50, 300);
      end
      mode_cnt--;
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Scoreboard: compare each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    sieve_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[20:16], m_axis_tdata[21],
              m_axis_tdata[53:22], m_axis_tdata[55:54]};
      if (expected_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got.totient !== want.totient || got.chain !== want.chain ||
            got.prime !== want.prime || got.total !== want.total ||
            got.status !== want.status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"Mismatch: exp tot=%0d chain=%0d prime=%0d total=%0d st=%0d,",
                      " got tot=%0d chain=%0d prime=%0d total=%0d st=%0d"},
                     want.totient, want.chain, want.prime, want.total, want.status,
                     got.totient, got.chain, got.prime, got.total, got.status);
        end
      end
    end
  end

  // Stimulus: directed table, then random phases with small limits.
  initial begin
    logic [16:0] lim_val;
    logic [15:0] idx;
    int r;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      case (dir_rows[k].kind)
        RK_LIMIT:  write_reg(tcs_pkg::REG_LIMIT, dir_rows[k].val);
        RK_TARGET: write_reg(tcs_pkg::REG_TARGET, dir_rows[k].val);
        default:   send_item(dir_rows[k].act, dir_rows[k].val[15:0],
                             dir_rows[k].typed, dir_rows[k].res);
      endcase
    end
    // Tables from the full build are still valid under a limit above the table depth.
    send_item(tcs_pkg::ACT_QUERY, 16'd299, 1'b0, R_ZERO);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      burst_mode = (ph % 4 == 3);
      r = $urandom_range(0, 9);
      if (r == 0) lim_val = 17'($urandom_range(0, 1));
      else if (r == 1) lim_val = 17'($urandom_range(1000, 3000));
      else lim_val = 17'($urandom_range(2, 400));
      write_reg(tcs_pkg::REG_LIMIT, lim_val);
      write_reg(tcs_pkg::REG_TARGET,
                17'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 31)
                                                : $urandom_range(1, 12)));
      if ($urandom_range(0, 4) != 0) begin
        send_item(tcs_pkg::ACT_BUILD, 16'($urandom), 1'b0, R_ZERO);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          idx = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, lim_val + 4));
          send_item(tcs_pkg::ACT_QUERY, idx, 1'b0, R_ZERO);
        end else if (r < 88) begin
          send_item(tcs_pkg::ACT_SUM, 16'($urandom), 1'b0, R_ZERO);
        end else if (r < 94) begin
          send_item(ACT_NONE, 16'($urandom), 1'b0, R_ZERO);
        end else begin
          send_item(tcs_pkg::ACT_BUILD, 16'($urandom), 1'b0, R_ZERO);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well above one full-depth build plus many builds at the largest random limits.
  initial begin
    repeat (20) #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
sv/tcs_pkg.sv
sv/totient_chain_sieve_top.sv
tb/sv/totient_chain_sieve_top_tb.sv
